// ===== hdl/mcic_pkg.sv =====
`timescale 1ns / 1ps

package mcic_pkg;

	// Width of the current samples and of the offset and reference registers
	localparam int SAMPLE_BITS = 12;

	localparam int DUTY_W     = 8;
	localparam int SHIFT_W    = 5;
	localparam int LIMIT_W    = 18;
	localparam int INTEG_W    = LIMIT_W + 1;
	localparam int SUM_W      = INTEG_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (LIMIT_W > SAMPLE_BITS) ? LIMIT_W : SAMPLE_BITS;

	// Reset values of the configuration registers
	localparam logic [SAMPLE_BITS-1:0] RST_ZERO_OFFSET      = SAMPLE_BITS'(2048);
	localparam logic [SHIFT_W-1:0]     RST_GAIN_SHIFT       = SHIFT_W'(10);
	localparam logic [SAMPLE_BITS-1:0] RST_MAX_REFERENCE    = SAMPLE_BITS'(2047);
	localparam logic [LIMIT_W-1:0]     RST_INTEGRATOR_LIMIT = LIMIT_W'(262143);
	localparam logic [DUTY_W-1:0]      RST_DUTY_MIN         = DUTY_W'(5);
	localparam logic [DUTY_W-1:0]      RST_DUTY_MAX         = DUTY_W'(204);

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_OFFSET      = 3'd0,
		REG_GAIN_SHIFT       = 3'd1,
		REG_MAX_REFERENCE    = 3'd2,
		REG_INTEGRATOR_LIMIT = 3'd3,
		REG_DUTY_MIN         = 3'd4,
		REG_DUTY_MAX         = 3'd5
	} reg_idx_t;

	typedef logic signed [INTEG_W-1:0] integ_t;

	// Current configuration as seen by the datapath
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] zero_offset;
		logic [SHIFT_W-1:0]     gain_shift;
		logic [SAMPLE_BITS-1:0] max_reference;
		logic [LIMIT_W-1:0]     integrator_limit;
		logic [DUTY_W-1:0]      duty_min;
		logic [DUTY_W-1:0]      duty_max;
	} cfg_t;

endpackage

// ===== hdl/mcic_cfg_regs.sv =====
`timescale 1ns / 1ps

module mcic_cfg_regs import mcic_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Decode the index and update one register per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_offset      <= RST_ZERO_OFFSET;
			cfg_q.gain_shift       <= RST_GAIN_SHIFT;
			cfg_q.max_reference    <= RST_MAX_REFERENCE;
			cfg_q.integrator_limit <= RST_INTEGRATOR_LIMIT;
			cfg_q.duty_min         <= RST_DUTY_MIN;
			cfg_q.duty_max         <= RST_DUTY_MAX;
		end else if (wr_en) begin
			case (wr_index)
				REG_ZERO_OFFSET:      cfg_q.zero_offset      <= wr_data[SAMPLE_BITS-1:0];
				REG_GAIN_SHIFT:       cfg_q.gain_shift       <= wr_data[SHIFT_W-1:0];
				REG_MAX_REFERENCE:    cfg_q.max_reference    <= wr_data[SAMPLE_BITS-1:0];
				REG_INTEGRATOR_LIMIT: cfg_q.integrator_limit <= wr_data[LIMIT_W-1:0];
				REG_DUTY_MIN:         cfg_q.duty_min         <= wr_data[DUTY_W-1:0];
				REG_DUTY_MAX:         cfg_q.duty_max         <= wr_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/mcic_datapath.sv =====
`timescale 1ns / 1ps

module mcic_datapath import mcic_pkg::*; (
	input  cfg_t                   cfg,
	input  integ_t                 integ,
	input  logic [SAMPLE_BITS-1:0] reference_current,
	input  logic [SAMPLE_BITS-1:0] measured_current,
	input  logic                   limit_enable,
	input  logic [DUTY_W-1:0]      duty_cap,
	output integ_t                 integ_next,
	output logic [DUTY_W-1:0]      duty
);

	logic [SAMPLE_BITS-1:0]   ref_clamped;
	logic signed [SUM_W-1:0]  integ_ext;
	logic signed [SUM_W-1:0]  offset_ext;
	logic signed [SUM_W-1:0]  ref_ext;
	logic signed [SUM_W-1:0]  meas_ext;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  lim_pos;
	logic signed [SUM_W-1:0]  lim_neg;
	logic signed [SUM_W-1:0]  sat;
	logic [LIMIT_W-1:0]       shifted;
	logic [DUTY_W-1:0]        duty_lim;

	// Clamp the reference
	assign ref_clamped = (reference_current > cfg.max_reference) ?
		cfg.max_reference : reference_current;

	// Accumulate the error into the integrator
	assign integ_ext  = SUM_W'(integ);
	assign offset_ext = SUM_W'(cfg.zero_offset);
	assign ref_ext    = SUM_W'(ref_clamped);
	assign meas_ext   = SUM_W'(measured_current);
	assign sum        = integ_ext + offset_ext + ref_ext - meas_ext;

	// Saturate symmetrically at the integrator limit
	assign lim_pos = SUM_W'(cfg.integrator_limit);
	assign lim_neg = -lim_pos;

	always_comb begin
		if (sum > lim_pos) begin
			sat = lim_pos;
		end else if (sum < lim_neg) begin
			sat = lim_neg;
		end else begin
			sat = sum;
		end
	end

	assign integ_next = sat[INTEG_W-1:0];

	// Scale by the gain; a negative integrator gives a zero level before the limits below
	assign shifted = sat[SUM_W-1] ? '0 : (sat[LIMIT_W-1:0] >> cfg.gain_shift);

	// Apply max, then min, then the optional cap
	always_comb begin
		if (shifted > LIMIT_W'(cfg.duty_max)) begin
			duty_lim = cfg.duty_max;
		end else begin
			duty_lim = shifted[DUTY_W-1:0];
		end
		if (duty_lim < cfg.duty_min) begin
			duty_lim = cfg.duty_min;
		end
		if (limit_enable && (duty_lim > duty_cap)) begin
			duty_lim = duty_cap;
		end
	end

	assign duty = duty_lim;

endmodule

// ===== hdl/motor_current_integral_controller.sv =====
`timescale 1ns / 1ps

// Integral current regulator: each accepted sample (reference, measurement, optional duty
// cap) yields one duty count and the updated integrator value. Throughput is one sample per
// clock while the sink keeps out_ready high; a result passes through the input register and
// then the result register before it can transfer out. The integrator feedback loop (add,
// saturate) is combinational between the input register and the result register, which sets
// the one-sample-per-clock rate. A stalled sink holds the result register and then the input
// register, so two samples wait inside before in_ready drops. Configuration writes are
// accepted at any time (cfg_ready is always high) but must be issued only while no sample is
// in flight.
module motor_current_integral_controller import mcic_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] reference_current,
	input  logic [SAMPLE_BITS-1:0] measured_current,
	input  logic                   limit_enable,
	input  logic [DUTY_W-1:0]      duty_cap,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [DUTY_W-1:0]      duty,
	output integ_t                 integrator_value,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                   cfg;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] ref_s1;
	logic [SAMPLE_BITS-1:0] meas_s1;
	logic                   cap_en_s1;
	logic [DUTY_W-1:0]      cap_s1;
	logic                   out_valid_q;
	logic [DUTY_W-1:0]      duty_q;
	integ_t                 integ_q;
	integ_t                 integ_next;
	logic [DUTY_W-1:0]      duty_next;
	logic                   load_out;
	logic                   load_s1;

	assign cfg_ready = 1'b1;

	mcic_cfg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: the input register advances whenever the result register frees up
	assign load_out = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || load_out;
	assign load_s1  = in_valid && in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			ref_s1    <= reference_current;
			meas_s1   <= measured_current;
			cap_en_s1 <= limit_enable;
			cap_s1    <= duty_cap;
		end
	end

	mcic_datapath u_dp (
		.cfg               (cfg),
		.integ             (integ_q),
		.reference_current (ref_s1),
		.measured_current  (meas_s1),
		.limit_enable      (cap_en_s1),
		.duty_cap          (cap_s1),
		.integ_next        (integ_next),
		.duty              (duty_next)
	);

	// Result register and integrator state advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			integ_q     <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				integ_q     <= integ_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			duty_q <= duty_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign duty             = duty_q;
	assign integrator_value = integ_q;

	// A held result always shows the current integrator state
	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (integrator_value == integ_q))
		else $error("result integrator differs from state");

	// A result moved into the output register is presented next cycle
	a_load_gives_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("loaded result not presented");

	// Input stalls only when both registers are full and the sink is stalled
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without back-pressure");

	// Saturation keeps the integrator off the most negative code
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q != {1'b1, {(INTEG_W-1){1'b0}}})
		else $error("integrator outside symmetric range");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import mcic_pkg::*;

	localparam int PHASES      = 14;
	localparam int PHASE_ITEMS = 125;
	localparam int LONG_HOLD   = 300;
	localparam int PLAN_ROWS   = 32;

	typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;

	// One row of the directed plan: a sample or a register write
	typedef struct {
		step_kind_t kind;
		reg_idx_t   idx;
		int         value;
		int         target;
		int         sensed;
		bit         en;
		int         cap;
		bit         typed;
		int         exp_duty;
		int         exp_integ;
	} step_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		integ_t            integ;
	} ctrl_out_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [SAMPLE_BITS-1:0] reference_current;
	logic [SAMPLE_BITS-1:0] measured_current;
	logic                   limit_enable;
	logic [DUTY_W-1:0]      duty_cap;
	logic                   out_valid;
	logic                   out_ready;
	logic [DUTY_W-1:0]      duty;
	integ_t                 integrator_value;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Known result attached to the sample currently offered
	bit                row_typed;
	logic [DUTY_W-1:0] typed_duty;
	integ_t            typed_integ;

	// Regulator mirror: integrator and register copy
	int        integ_acc;
	cfg_t      cfg_now;
	ctrl_out_t awaited[$];
	int        mismatches;

	bit sender_gaps;
	bit sink_stalls;
	bit hold_off;

	step_t plan [0:PLAN_ROWS-1] = '{
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0,    0, 2048, 1'b0,   0, 1'b1,   5,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0, 4095,    0, 1'b1, 255, 1'b1,   5,  4095},
		'{STEP_WRITE,  REG_GAIN_SHIFT,            0,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0, 2047,    0, 1'b0,   0, 1'b1, 204,  8190},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0, 2047,    0, 1'b1, 100, 1'b1, 100, 12285},
		// cap below the minimum wins
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0,    0, 2048, 1'b1,   3, 1'b1,   3, 12285},
		// minimum above the maximum
		'{STEP_WRITE,  REG_DUTY_MIN,            250,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0,    0, 2048, 1'b0,   0, 1'b1, 250, 12285},
		'{STEP_WRITE,  REG_DUTY_MIN,              0,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_WRITE,  REG_DUTY_MAX,            255,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		// lowered limit saturates the integrator at the next sample
		'{STEP_WRITE,  REG_INTEGRATOR_LIMIT,   1000,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0,    0, 2048, 1'b0,   0, 1'b1, 255,  1000},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0,    0, 4095, 1'b0,   0, 1'b1,   0, -1000},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0,    0, 4095, 1'b1,   0, 1'b1,   0, -1000},
		// zero limit pins the integrator
		'{STEP_WRITE,  REG_INTEGRATOR_LIMIT,      0,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0, 2047,    0, 1'b0,   0, 1'b1,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0,    0, 4095, 1'b1, 255, 1'b1,   0,     0},
		'{STEP_WRITE,  REG_ZERO_OFFSET,        4095,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_WRITE,  REG_MAX_REFERENCE,      4095,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_WRITE,  REG_INTEGRATOR_LIMIT, 262143,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_WRITE,  REG_GAIN_SHIFT,           31,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0, 4095,    0, 1'b0,   0, 1'b1,   0,  8190},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0, 4095, 4095, 1'b1, 255, 1'b1,   0, 12285},
		'{STEP_WRITE,  REG_GAIN_SHIFT,            5,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0, 4095,    0, 1'b0,   0, 1'b1, 255, 20475},
		'{STEP_WRITE,  REG_ZERO_OFFSET,           0,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_WRITE,  REG_MAX_REFERENCE,         0,    0,    0, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0, 4095, 4095, 1'b0,   0, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0,    0,    0, 1'b1, 128, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0, 2048,    1, 1'b1, 255, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0,    1, 4094, 1'b0, 170, 1'b0,   0,     0},
		'{STEP_SAMPLE, REG_ZERO_OFFSET,           0, 2730, 1365, 1'b1,  85, 1'b0,   0,     0}
	};

	motor_current_integral_controller dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.reference_current (reference_current),
		.measured_current  (measured_current),
		.limit_enable      (limit_enable),
		.duty_cap          (duty_cap),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.duty              (duty),
		.integrator_value  (integrator_value),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// Advance the integrator by one sample and derive the duty count
	function automatic ctrl_out_t regulate(input logic [SAMPLE_BITS-1:0] target,
			input logic [SAMPLE_BITS-1:0] sensed, input logic en, input logic [DUTY_W-1:0] cap);
		ctrl_out_t res;
		logic [SAMPLE_BITS-1:0] clamped;
		int lim;
		int sum;
		int unsigned level;
		clamped = (target > cfg_now.max_reference) ? cfg_now.max_reference : target;
		lim = int'(cfg_now.integrator_limit);
		sum = integ_acc + int'(cfg_now.zero_offset) + int'(clamped) - int'(sensed);
		if (sum > lim) sum = lim;
		if (sum < -lim) sum = -lim;
		integ_acc = sum;
		level = (sum >= 0) ? (unsigned'(sum) >> cfg_now.gain_shift) : 0;
		if (level > cfg_now.duty_max) level = cfg_now.duty_max;
		if (level < cfg_now.duty_min) level = cfg_now.duty_min;
		if (en && level > cap) level = cap;
		res.duty = level[DUTY_W-1:0];
		res.integ = integ_t'(sum);
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// Track register writes, predict on input transfers, check output transfers
	always @(posedge clk or negedge arst_n) begin : watch
		ctrl_out_t calc;
		ctrl_out_t want;
		if (!arst_n) begin
			integ_acc = 0;
			cfg_now.zero_offset = RST_ZERO_OFFSET;
			cfg_now.gain_shift = RST_GAIN_SHIFT;
			cfg_now.max_reference = RST_MAX_REFERENCE;
			cfg_now.integrator_limit = RST_INTEGRATOR_LIMIT;
			cfg_now.duty_min = RST_DUTY_MIN;
			cfg_now.duty_max = RST_DUTY_MAX;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_ZERO_OFFSET:      cfg_now.zero_offset = cfg_data[SAMPLE_BITS-1:0];
					REG_GAIN_SHIFT:       cfg_now.gain_shift = cfg_data[SHIFT_W-1:0];
					REG_MAX_REFERENCE:    cfg_now.max_reference = cfg_data[SAMPLE_BITS-1:0];
					REG_INTEGRATOR_LIMIT: cfg_now.integrator_limit = cfg_data[LIMIT_W-1:0];
					REG_DUTY_MIN:         cfg_now.duty_min = cfg_data[DUTY_W-1:0];
					REG_DUTY_MAX:         cfg_now.duty_max = cfg_data[DUTY_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				calc = regulate(reference_current, measured_current, limit_enable, duty_cap);
				if (row_typed) begin
					calc.duty = typed_duty;
					calc.integ = typed_integ;
				end
				awaited.push_back(calc);
			end
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result, duty %0d integrator %0d", $time,
						duty, integrator_value);
					mismatches++;
				end else begin
					want = awaited.pop_front();
					if (duty !== want.duty) begin
						$display("%0t: duty expected %0d, got %0d", $time, want.duty, duty);
						mismatches++;
					end
					if (integrator_value !== want.integ) begin
						$display("%0t: integrator expected %0d, got %0d", $time,
							want.integ, integrator_value);
						mismatches++;
					end
				end
			end
		end
	end

	// Result side: ready bursts, random stalls, and one long hold-off
	initial begin
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_off = 1'b0;
			end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(negedge clk);
			end
		end
	end

	// Offer one sample and hold it until the transfer, then maybe pause
	task automatic offer(input logic [SAMPLE_BITS-1:0] target, input logic [SAMPLE_BITS-1:0] sensed,
			input logic en, input logic [DUTY_W-1:0] cap, input bit typed,
			input logic [DUTY_W-1:0] e_duty, input integ_t e_integ);
		reference_current <= target;
		measured_current <= sensed;
		limit_enable <= en;
		duty_cap <= cap;
		row_typed <= typed;
		typed_duty <= e_duty;
		typed_integ <= e_integ;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	// Leave cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Stop offering and drain every outstanding result
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited.size() != 0) @(negedge clk);
	endtask

	initial begin : run
		cfg_t pick;
		bit cfg_open;
		int drift;
		int sweep;
		int roll;
		int aim;
		logic [SAMPLE_BITS-1:0] target;
		logic [SAMPLE_BITS-1:0] sensed;
		logic [SAMPLE_BITS-1:0] clamped;
		arst_n = 1'b0;
		in_valid = 1'b0;
		reference_current = '0;
		measured_current = '0;
		limit_enable = 1'b0;
		duty_cap = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		row_typed = 1'b0;
		typed_duty = '0;
		typed_integ = '0;
		mismatches = 0;
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		hold_off = 1'b0;
		cfg_open = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed plan: extremes, clamps and integrator corner cases
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].kind == STEP_WRITE) begin
				if (!cfg_open) settle();
				write_reg(plan[i].idx, CFG_DATA_W'(plan[i].value));
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) cfg_valid <= 1'b0;
				cfg_open = 1'b0;
				offer(SAMPLE_BITS'(plan[i].target), SAMPLE_BITS'(plan[i].sensed), plan[i].en,
					DUTY_W'(plan[i].cap), plan[i].typed, DUTY_W'(plan[i].exp_duty),
					integ_t'(plan[i].exp_integ));
			end
		end

		// Random phases, each under its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: begin
					pick = '0;
					drift = 0;
					sweep = 10;
				end
				1: begin
					pick.zero_offset = '1;
					pick.gain_shift = '1;
					pick.max_reference = '1;
					pick.integrator_limit = '1;
					pick.duty_min = '1;
					pick.duty_max = '1;
					drift = 1;
					sweep = 60;
				end
				2: begin
					pick.zero_offset = '0;
					pick.gain_shift = SHIFT_W'(10);
					pick.max_reference = '1;
					pick.integrator_limit = '1;
					pick.duty_min = '0;
					pick.duty_max = '1;
					drift = -1;
					sweep = 60;
				end
				PHASES - 1: begin
					pick.zero_offset = RST_ZERO_OFFSET;
					pick.gain_shift = RST_GAIN_SHIFT;
					pick.max_reference = RST_MAX_REFERENCE;
					pick.integrator_limit = RST_INTEGRATOR_LIMIT;
					pick.duty_min = RST_DUTY_MIN;
					pick.duty_max = RST_DUTY_MAX;
					drift = 0;
					sweep = 5;
				end
				default: begin
					pick.zero_offset = $urandom_range(0, 1) ?
						SAMPLE_BITS'($urandom_range(1848, 2248)) : SAMPLE_BITS'($urandom_range(0, 4095));
					pick.gain_shift = ($urandom_range(0, 7) == 0) ?
						SHIFT_W'($urandom_range(0, 31)) : SHIFT_W'($urandom_range(5, 12));
					pick.max_reference = SAMPLE_BITS'($urandom_range(0, 4095));
					case ($urandom_range(0, 3))
						0: pick.integrator_limit = LIMIT_W'($urandom_range(0, 4000));
						1: pick.integrator_limit = LIMIT_W'($urandom_range(0, 262143));
						default: pick.integrator_limit = '1;
					endcase
					pick.duty_min = DUTY_W'($urandom_range(0, 40));
					pick.duty_max = ($urandom_range(0, 9) == 0) ?
						DUTY_W'($urandom_range(0, 60)) : DUTY_W'($urandom_range(120, 255));
					drift = int'($urandom_range(0, 2)) - 1;
					sweep = $urandom_range(0, 20);
				end
			endcase
			write_reg(REG_ZERO_OFFSET, CFG_DATA_W'(pick.zero_offset));
			write_reg(REG_GAIN_SHIFT, CFG_DATA_W'(pick.gain_shift));
			write_reg(REG_MAX_REFERENCE, CFG_DATA_W'(pick.max_reference));
			write_reg(REG_INTEGRATOR_LIMIT, CFG_DATA_W'(pick.integrator_limit));
			write_reg(REG_DUTY_MIN, CFG_DATA_W'(pick.duty_min));
			write_reg(REG_DUTY_MAX, CFG_DATA_W'(pick.duty_max));
			cfg_valid <= 1'b0;

			// Pick the idling mix; the final phase runs flat out
			if (phase == PHASES - 1) begin
				sender_gaps = 1'b0;
				sink_stalls = 1'b0;
			end else if (phase == 4) begin
				sender_gaps = 1'b0;
				sink_stalls = 1'b1;
				hold_off = 1'b1;
			end else begin
				sender_gaps = ($urandom_range(0, 3) != 0);
				sink_stalls = ($urandom_range(0, 3) != 0);
			end

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				target = SAMPLE_BITS'($urandom_range(0, 4095));
				roll = $urandom_range(0, 99);
				if (roll < sweep) begin
					if (drift > 0 || (drift == 0 && $urandom_range(0, 1))) begin
						target = '1;
						sensed = '0;
					end else begin
						target = '0;
						sensed = '1;
					end
				end else if (roll < sweep + 25) begin
					sensed = SAMPLE_BITS'($urandom_range(0, 4095));
				end else begin
					// Hold the error near zero with a small bias
					clamped = (target > pick.max_reference) ? pick.max_reference : target;
					aim = int'(pick.zero_offset) + int'(clamped)
						+ int'($urandom_range(0, 128)) - 64 - drift * 40;
					if (aim < 0) aim = 0;
					if (aim > 4095) aim = 4095;
					sensed = SAMPLE_BITS'(aim);
				end
				offer(target, sensed, 1'($urandom_range(0, 1)),
					($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
						: DUTY_W'($urandom_range(0, 255)),
					1'b0, '0, '0);
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/mcic_pkg.sv
hdl/mcic_cfg_regs.sv
hdl/mcic_datapath.sv
hdl/motor_current_integral_controller.sv
tb/sv/testbench.sv
